// ----- src/avsm_pkg.sv -----
`timescale 1ns / 1ps
// Package of the audio/video sync matcher: beat payload types, command and
// status codes, and the control structs between controller and datapath.
// Depends on nothing.
package avsm_pkg;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_SYNC  = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [2:0] ST_PUSHED   = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_MATCHED  = 3'd2;
	localparam logic [2:0] ST_NO_MATCH = 3'd3;
	localparam logic [2:0] ST_FLUSHED  = 3'd4;

	localparam logic [31:0] THRESHOLD_RESET = 32'd40000;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] item_tag;
		logic [47:0] item_timestamp;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] audio_tag;
		logic [15:0] video_tag;
		logic [47:0] video_timestamp;
		logic [7:0]  dropped_count;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic eval;
		logic resolve;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic stop;
		logic out_free;
	} dp_stat_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] value);
		sat_inc = (value == 8'hFF) ? value : value + 8'd1;
	endfunction

endpackage

// ----- src/avsm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module avsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- src/avsm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the sync matcher: sequences push, flush and the
// queue walk of a sync. Depends on avsm_pkg.
module avsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_command,
	input  avsm_pkg::dp_stat_t    stat,
	output logic                  in_stall,
	output avsm_pkg::ctrl_cmd_t   cmd
);
	import avsm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_READ    = 5'b00010,
		S_EVAL    = 5'b00100,
		S_RESOLVE = 5'b01000,
		S_FINISH  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					case (in_command) inside
						CMD_PUSH, CMD_FLUSH: state_d = S_FINISH;
						CMD_SYNC:            state_d = S_READ;
						default:             state_d = S_IDLE;
					endcase
				end
			end
			S_READ: begin
				cmd.rd_en = !stat.empty;
				state_d = stat.empty ? S_RESOLVE : S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = stat.stop ? S_RESOLVE : S_READ;
			end
			S_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/avsm_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the sync matcher: queue pointers, threshold register, best-entry
// tracking, result and output registers. Depends on avsm_pkg and avsm_ram.
module avsm_datapath #(
	parameter int QUEUE_DEPTH = 128,
	parameter int TIME_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [31:0]           cfg_wr_data,
	input  avsm_pkg::in_item_t    in_data,
	input  avsm_pkg::ctrl_cmd_t   cmd,
	input  logic                  out_stall,
	output avsm_pkg::dp_stat_t    stat,
	output logic                  out_valid,
	output avsm_pkg::out_item_t   out_data
);
	import avsm_pkg::*;

	localparam int TW   = (TIME_BITS < 48) ? TIME_BITS : 48;
	localparam int CW   = (TW > 33) ? TW : 33;
	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW   = $clog2(2 * QUEUE_DEPTH);
	localparam int RW   = 16 + TW;

	function automatic out_item_t make_res(input logic [2:0] status,
			input logic [15:0] audio_tag, input logic [15:0] video_tag,
			input logic [47:0] video_timestamp, input logic [7:0] dropped_count);
		out_item_t r;
		r.status          = status;
		r.audio_tag       = audio_tag;
		r.video_tag       = video_tag;
		r.video_timestamp = video_timestamp;
		r.dropped_count   = dropped_count;
		return r;
	endfunction

	logic [AW-1:0]   head_q;
	logic [CNTW-1:0] count_q;
	logic [31:0]     thr_q;
	logic            have_q;
	logic            out_valid_q;
	logic [TW-1:0]   ts_q;
	logic [15:0]     atag_q;
	logic [15:0]     best_tag_q;
	logic [TW-1:0]   best_time_q;
	logic [TW-1:0]   best_gap_q;
	logic [7:0]      drop_q;
	out_item_t       res_q;
	out_item_t       out_data_q;

	logic [TW-1:0]   in_ts;
	logic            full;
	logic [SW-1:0]   slot_sum;
	logic [AW-1:0]   slot;
	logic [AW-1:0]   head_inc;
	logic [AW-1:0]   head_dec;
	logic [RW-1:0]   rd_data;
	logic [TW-1:0]   v_time;
	logic [15:0]     v_tag;
	logic [TW-1:0]   gap;
	logic            take;
	logic            late;
	logic [TW-1:0]   new_gap;
	logic [CW-1:0]   half_ceil;
	logic            over;
	logic            later;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [RW-1:0]   wr_data;
	logic            is_push;
	logic            is_sync;
	logic            is_flush;

	assign in_ts    = in_data.item_timestamp[TW-1:0];
	assign is_push  = cmd.accept && (in_data.command == CMD_PUSH);
	assign is_sync  = cmd.accept && (in_data.command == CMD_SYNC);
	assign is_flush = cmd.accept && (in_data.command == CMD_FLUSH);

	assign full     = (count_q == CNTW'(QUEUE_DEPTH));
	assign slot_sum = SW'(head_q) + SW'(count_q);
	assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? AW'(slot_sum - SW'(QUEUE_DEPTH))
	                                                  : AW'(slot_sum);
	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(QUEUE_DEPTH - 1) : head_q - AW'(1);

	assign v_time    = rd_data[TW-1:0];
	assign v_tag     = rd_data[RW-1:TW];
	assign gap       = (v_time >= ts_q) ? v_time - ts_q : ts_q - v_time;
	assign take      = !have_q || (gap < best_gap_q);
	assign late      = !take && (v_time > ts_q) && (CW'(gap) > CW'(thr_q));
	assign new_gap   = take ? gap : best_gap_q;
	assign half_ceil = CW'((33'(thr_q) + 33'd1) >> 1);
	assign over      = CW'(best_gap_q) > CW'(thr_q);
	assign later     = best_time_q > ts_q;

	assign wr_en   = (is_push && !full) || (cmd.resolve && have_q && over && later);
	assign wr_addr = cmd.resolve ? head_dec : slot;
	assign wr_data = cmd.resolve ? {best_tag_q, best_time_q} : {in_data.item_tag, in_ts};

	avsm_ram #(
		.WIDTH (RW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	assign stat.empty    = (count_q == '0);
	assign stat.stop     = late || (CW'(new_gap) < half_ceil);
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			thr_q       <= THRESHOLD_RESET;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (is_push && !full) begin
				count_q <= count_q + CNTW'(1);
			end
			if (is_flush) begin
				head_q  <= '0;
				count_q <= '0;
			end
			if (is_sync) begin
				have_q <= 1'b0;
			end
			if (cmd.eval) begin
				if (!late) begin
					head_q  <= head_inc;
					count_q <= count_q - CNTW'(1);
					have_q  <= 1'b1;
				end
			end
			if (cmd.resolve && have_q && over && later) begin
				head_q  <= head_dec;
				count_q <= count_q + CNTW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_push) begin
			res_q <= make_res(full ? ST_FULL : ST_PUSHED, 16'd0, 16'd0, 48'd0, 8'd0);
		end
		if (is_flush) begin
			res_q <= make_res(ST_FLUSHED, 16'd0, 16'd0, 48'd0,
				(32'(count_q) > 32'd255) ? 8'd255 : 8'(count_q));
		end
		if (is_sync) begin
			ts_q   <= in_ts;
			atag_q <= in_data.item_tag;
			drop_q <= 8'd0;
		end
		if (cmd.eval && !late) begin
			if (have_q) begin
				drop_q <= sat_inc(drop_q);
			end
			if (take) begin
				best_tag_q  <= v_tag;
				best_time_q <= v_time;
				best_gap_q  <= gap;
			end
		end
		if (cmd.resolve) begin
			if (!have_q) begin
				res_q <= make_res(ST_NO_MATCH, atag_q, 16'd0, 48'd0, drop_q);
			end else if (over) begin
				res_q <= make_res(ST_NO_MATCH, atag_q, 16'd0, 48'd0,
					later ? drop_q : sat_inc(drop_q));
			end else begin
				res_q <= make_res(ST_MATCHED, atag_q, best_tag_q, 48'(best_time_q), drop_q);
			end
		end
		if (cmd.load_out) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- src/av_sync_video_matcher_core.sv -----
`timescale 1ns / 1ps
// Sequence: a push or flush result goes to the result register, then into the output register
// once that is free; a sync walks the queue entry by entry, then resolves and loads its result.
// Throughput: one item at a time; each entry read passes a RAM read and an evaluate state,
// and the next beat is taken once the result is loaded into the output register.
// Reset: queue empty, head at zero, threshold 40000, output empty; the queue RAM
// itself is not cleared and needs no clearing pass.
module av_sync_video_matcher_core #(
	parameter int QUEUE_DEPTH = 128,
	parameter int TIME_BITS   = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  avsm_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output avsm_pkg::out_item_t  out_data
);
	import avsm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	avsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_data.command),
		.stat       (stat),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	avsm_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.out_stall   (out_stall),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("Output register loaded while a result beat is still held.");

	a_sync_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.command == CMD_SYNC) |=> in_stall)
		else $error("Input taken again directly after a sync beat.");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("Result beat appeared without a controller load.");
`endif

endmodule
